// File: design/qjt_pkg.sv
// Shared constants and payload types for the quintic joint trajectory generator.
`timescale 1ns / 1ps
`default_nettype none

package qjt_pkg;

   localparam int JOINT_COUNT = 4;
   localparam int MAX_STEPS   = 64;
   localparam int ANGLE_W     = 16;
   localparam int CFG_W       = 7;

   localparam int STEP_W = $clog2(MAX_STEPS);
   localparam int DEN_W  = STEP_W;

   // Q1.16 time values, Q5.16 blend value, Q4.16 polynomial tail
   localparam int Q_FRAC = 16;
   localparam int Q_W    = Q_FRAC + 1;
   localparam int P_W    = Q_FRAC + 4;
   localparam int S_W    = Q_W + P_W - Q_FRAC;

   localparam int DIFF_W = ANGLE_W + 1;
   localparam int MUL_W  = ((DIFF_W > S_W) ? DIFF_W : S_W) + 1;
   localparam int PROD_W = 2 * MUL_W;

   localparam logic [CFG_W-1:0] STEP_COUNT_RESET = CFG_W'(50);
   localparam logic [CFG_W-1:0] STEP_COUNT_MIN   = CFG_W'(2);
   localparam logic [CFG_W-1:0] STEP_COUNT_MAX   = CFG_W'(MAX_STEPS);

   localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << Q_FRAC;

   // s(t) = 6t^5 - 15t^4 + 10t^3
   localparam int BLEND_C5 = 6;
   localparam int BLEND_C4 = 15;
   localparam int BLEND_C3 = 10;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] start_angle_1;
      logic signed [ANGLE_W-1:0] start_angle_2;
      logic signed [ANGLE_W-1:0] start_angle_3;
      logic signed [ANGLE_W-1:0] start_angle_4;
      logic signed [ANGLE_W-1:0] goal_angle_1;
      logic signed [ANGLE_W-1:0] goal_angle_2;
      logic signed [ANGLE_W-1:0] goal_angle_3;
      logic signed [ANGLE_W-1:0] goal_angle_4;
   } req_payload_type;

   typedef struct packed {
      logic        [STEP_W-1:0]  step_index;
      logic signed [ANGLE_W-1:0] way_angle_1;
      logic signed [ANGLE_W-1:0] way_angle_2;
      logic signed [ANGLE_W-1:0] way_angle_3;
      logic signed [ANGLE_W-1:0] way_angle_4;
      logic                      last_point;
   } rsp_payload_type;

   typedef struct packed {
      logic             done;
      logic [Q_W-1:0]   quot;
      logic [DEN_W-1:0] rem;
   } div_result_type;

endpackage

`default_nettype wire

// File: design/qjt_div.sv
// Restoring divider: one over (step_count - 1) in Q1.16, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module qjt_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [qjt_pkg::DEN_W-1:0] divisor,
   output qjt_pkg::div_result_type        result
);
   import qjt_pkg::*;

   localparam int CNT_W = $clog2(Q_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [Q_W-1:0]   quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] dvs_ff, dvs_in;

   logic [DEN_W:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[Q_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = Q_ONE;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[Q_W-2:0], 1'b1};
         end else begin
            rem_in = DEN_W'(trial);
            quo_in = {quo_ff[Q_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign result.done = done_ff;
   assign result.quot = quo_ff;
   assign result.rem  = rem_ff;

endmodule

`default_nettype wire

// File: design/quintic_joint_trajectory_top.sv
// Quintic rest-to-rest joint trajectory generator, top level.
//
//   channel | ports                          | moves
//   --------+--------------------------------+--------------------------------------
//   req     | req_valid req_ready req_data   | start and goal angles, four joints
//   rsp     | rsp_valid rsp_ready rsp_data   | one way-point per item, step_count items
//   csr     | csr_valid csr_ready csr_wdata  | step_count, clamped to 2..64
//
// A request first runs the divider (17 quotient bits, then the done flag); each way-point then
// takes seven products through the one shared 22x22 multiplier, each followed by a rounding
// step, and a push step that hands the way-point to the output register. req_ready is high
// only between requests. The output register lets the next way-point be computed while the
// current one is stalled. Reset is synchronous and sets step_count to 50.
`timescale 1ns / 1ps
`default_nettype none

module quintic_joint_trajectory_top (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_ready,
   input  wire qjt_pkg::req_payload_type  req_data,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_ready,
   output qjt_pkg::rsp_payload_type       rsp_data,
   input  wire logic                      csr_valid,
   output      logic                      csr_ready,
   input  wire logic [qjt_pkg::CFG_W-1:0] csr_wdata
);
   import qjt_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_POST = 3'd3;
   localparam logic [2:0] ST_PUSH = 3'd4;

   localparam int OP_W   = $clog2(3 + JOINT_COUNT);
   localparam int JIDX_W = $clog2(JOINT_COUNT);
   localparam logic [OP_W-1:0] OP_SQ    = OP_W'(0);
   localparam logic [OP_W-1:0] OP_CUBE  = OP_W'(1);
   localparam logic [OP_W-1:0] OP_BLEND = OP_W'(2);
   localparam logic [OP_W-1:0] OP_JOINT = OP_W'(3);
   localparam logic [OP_W-1:0] OP_LAST  = OP_W'(3 + JOINT_COUNT - 1);

   localparam int RND_W = PROD_W - Q_FRAC;
   localparam int SUM_W = RND_W + 1;
   localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (Q_FRAC - 1);
   localparam logic signed [SUM_W-1:0]  ANGLE_HI = SUM_W'((1 << (ANGLE_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0]  ANGLE_LO = -(SUM_W'(1) <<< (ANGLE_W - 1));

   logic [2:0]             state_ff, state_in;
   logic [OP_W-1:0]        op_ff, op_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [DEN_W-1:0]       den_ff, den_in;
   logic [CFG_W-1:0]       step_count_ff, step_count_in;
   logic [Q_W-1:0]         t_ff, t_in;
   logic [Q_W-1:0]         q0_ff, q0_in;
   logic [DEN_W-1:0]       r0_ff, r0_in;
   logic [DEN_W-1:0]       racc_ff, racc_in;
   logic [Q_W-1:0]         t2_ff, t2_in;
   logic [Q_W-1:0]         t3_ff, t3_in;
   logic [P_W-1:0]         p_ff, p_in;
   logic [S_W-1:0]         s_ff, s_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ANGLE_W-1:0] start_ff [JOINT_COUNT];
   logic signed [ANGLE_W-1:0] start_in [JOINT_COUNT];
   logic signed [DIFF_W-1:0]  diff_ff [JOINT_COUNT];
   logic signed [DIFF_W-1:0]  diff_in [JOINT_COUNT];
   logic signed [ANGLE_W-1:0] way_ff [JOINT_COUNT];
   logic signed [ANGLE_W-1:0] way_in [JOINT_COUNT];
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   logic signed [ANGLE_W-1:0] req_start [JOINT_COUNT];
   logic signed [ANGLE_W-1:0] req_goal [JOINT_COUNT];
   logic                   div_start;
   div_result_type         div_res;
   logic [JIDX_W-1:0]      jidx;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_rnd;
   logic signed [SUM_W-1:0] way_sum;
   logic [P_W:0]           p_full;
   logic [DEN_W:0]         r_sum;
   logic                   r_wrap;

   assign req_start[0] = req_data.start_angle_1;
   assign req_start[1] = req_data.start_angle_2;
   assign req_start[2] = req_data.start_angle_3;
   assign req_start[3] = req_data.start_angle_4;
   assign req_goal[0]  = req_data.goal_angle_1;
   assign req_goal[1]  = req_data.goal_angle_2;
   assign req_goal[2]  = req_data.goal_angle_3;
   assign req_goal[3]  = req_data.goal_angle_4;

   qjt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (DEN_W'(step_count_ff - CFG_W'(1))),
      .result  (div_res)
   );

   assign jidx = JIDX_W'(op_ff - OP_JOINT);

   // shared multiplier operand select
   always_comb begin
      case (op_ff)
         OP_SQ: begin
            mul_a = MUL_W'(t_ff);
            mul_b = MUL_W'(t_ff);
         end
         OP_CUBE: begin
            mul_a = MUL_W'(t2_ff);
            mul_b = MUL_W'(t_ff);
         end
         OP_BLEND: begin
            mul_a = MUL_W'(t3_ff);
            mul_b = MUL_W'(p_ff);
         end
         default: begin
            mul_a = MUL_W'(diff_ff[jidx]);
            mul_b = MUL_W'(s_ff);
         end
      endcase
   end

   assign prod_rnd = prod_ff + RND_HALF;
   assign way_sum  = SUM_W'(start_ff[jidx]) + SUM_W'($signed(prod_rnd[PROD_W-1:Q_FRAC]));
   assign p_full   = (P_W+1)'(BLEND_C5) * (P_W+1)'(t2_ff)
                   + ((P_W+1)'(BLEND_C3) << Q_FRAC)
                   - (P_W+1)'(BLEND_C4) * (P_W+1)'(t_ff);
   assign r_sum    = (DEN_W+1)'(racc_ff) + (DEN_W+1)'(r0_ff);
   assign r_wrap   = r_sum >= {1'b0, den_ff};

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      step_in       = step_ff;
      den_in        = den_ff;
      step_count_in = step_count_ff;
      t_in          = t_ff;
      q0_in         = q0_ff;
      r0_in         = r0_ff;
      racc_in       = racc_ff;
      t2_in         = t2_ff;
      t3_in         = t3_ff;
      p_in          = p_ff;
      s_in          = s_ff;
      prod_in       = prod_ff;
      start_in      = start_ff;
      diff_in       = diff_ff;
      way_in        = way_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      div_start     = 1'b0;

      if (csr_valid) begin
         if (csr_wdata < STEP_COUNT_MIN) begin
            step_count_in = STEP_COUNT_MIN;
         end else if (csr_wdata > STEP_COUNT_MAX) begin
            step_count_in = STEP_COUNT_MAX;
         end else begin
            step_count_in = csr_wdata;
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               for (int j = 0; j < JOINT_COUNT; j++) begin
                  start_in[j] = req_start[j];
                  diff_in[j]  = DIFF_W'(req_goal[j]) - DIFF_W'(req_start[j]);
               end
               den_in    = DEN_W'(step_count_ff - CFG_W'(1));
               step_in   = '0;
               t_in      = '0;
               racc_in   = '0;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               q0_in    = div_res.quot;
               r0_in    = div_res.rem;
               op_in    = OP_SQ;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_POST;
         end
         ST_POST: begin
            case (op_ff)
               OP_SQ: begin
                  t2_in = prod_rnd[Q_FRAC +: Q_W];
               end
               OP_CUBE: begin
                  t3_in = prod_rnd[Q_FRAC +: Q_W];
                  p_in  = p_full[P_W-1:0];
               end
               OP_BLEND: begin
                  s_in = prod_rnd[Q_FRAC +: S_W];
               end
               default: begin
                  if (way_sum > ANGLE_HI) begin
                     way_in[jidx] = ANGLE_HI[ANGLE_W-1:0];
                  end else if (way_sum < ANGLE_LO) begin
                     way_in[jidx] = ANGLE_LO[ANGLE_W-1:0];
                  end else begin
                     way_in[jidx] = way_sum[ANGLE_W-1:0];
                  end
               end
            endcase
            if (op_ff == OP_LAST) begin
               state_in = ST_PUSH;
            end else begin
               op_in    = op_ff + OP_W'(1);
               state_in = ST_MUL;
            end
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.step_index  = step_ff;
               rsp_data_in.way_angle_1 = way_ff[0];
               rsp_data_in.way_angle_2 = way_ff[1];
               rsp_data_in.way_angle_3 = way_ff[2];
               rsp_data_in.way_angle_4 = way_ff[3];
               rsp_data_in.last_point  = (step_ff == den_ff);
               if (step_ff == den_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  // t steps by q0 plus a carry from the running remainder
                  step_in  = step_ff + STEP_W'(1);
                  t_in     = t_ff + q0_ff + Q_W'(r_wrap);
                  racc_in  = r_wrap ? DEN_W'(r_sum - {1'b0, den_ff}) : DEN_W'(r_sum);
                  op_in    = OP_SQ;
                  state_in = ST_MUL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_SQ;
         step_ff       <= '0;
         step_count_ff <= STEP_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         op_ff         <= op_in;
         step_ff       <= step_in;
         step_count_ff <= step_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      den_ff      <= den_in;
      t_ff        <= t_in;
      q0_ff       <= q0_in;
      r0_ff       <= r0_in;
      racc_ff     <= racc_in;
      t2_ff       <= t2_in;
      t3_ff       <= t3_in;
      p_ff        <= p_in;
      s_ff        <= s_in;
      prod_ff     <= prod_in;
      start_ff    <= start_in;
      diff_ff     <= diff_in;
      way_ff      <= way_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for the quintic joint trajectory generator.
`timescale 1ns / 1ps

module tb;
   import qjt_pkg::*;

   typedef longint unsigned u64_t;

   localparam u64_t    HALF_LSB     = 64'd32768;
   localparam longint  ANGLE_LO     = -(64'sd1 <<< (ANGLE_W - 1));
   localparam longint  ANGLE_HI     = (64'sd1 <<< (ANGLE_W - 1)) - 1;
   localparam int      RANDOM_PHASES = 12;
   localparam int      PHASE_ITEMS  = 39;
   localparam longint  CYCLE_LIMIT  = 8_000_000;

   typedef struct {
      bit               do_write;
      logic [CFG_W-1:0] csr_value;
      int unsigned      typed_points;  // 0: count and way-points come from the predictor
      req_payload_type  rq;
   } directed_row_type;

   // start 1..4, goal 1..4; typed rows expect start on the first point, goal on the last
   directed_row_type directed_plan [14] = '{
      '{1'b0, 7'd0,   50, 128'h0000_1000_f000_8000_1000_0000_8000_7fff},
      '{1'b1, 7'd0,    2, 128'h8000_8000_8000_8000_7fff_7fff_7fff_7fff},
      '{1'b0, 7'd0,    2, 128'h7fff_7fff_7fff_7fff_8000_8000_8000_8000},
      '{1'b1, 7'd1,    2, 128'h1234_8000_7fff_0000_1234_8000_7fff_0000},
      '{1'b1, 7'd127, 64, 128'h8000_7fff_0000_ffff_7fff_8000_ffff_0001},
      '{1'b0, 7'd0,   64, 128'h0000_0000_0000_0000_7fff_8000_4000_c000},
      '{1'b1, 7'd65,  64, 128'hffff_0001_aaaa_5555_0001_ffff_5555_aaaa},
      '{1'b1, 7'd64,  64, 128'h0800_f800_0001_8001_f800_0800_7ffe_8000},
      '{1'b1, 7'd3,    3, 128'h8000_0000_7fff_c000_7fff_0000_8000_4000},
      '{1'b1, 7'd2,    2, 128'h0001_ffff_0000_0000_ffff_0001_0001_ffff},
      '{1'b1, 7'd7,    0, 128'h3244_cdbc_1922_e6de_cdbc_3244_e6de_1922},
      '{1'b0, 7'd0,    0, 128'h0fff_f001_7000_9000_f001_0fff_9000_7000},
      '{1'b1, 7'd50,  50, 128'h2000_e000_0400_fc00_e000_2000_fc00_0400},
      '{1'b1, 7'd10,   0, 128'h5555_aaaa_0f0f_f0f0_aaaa_5555_f0f0_0f0f}
   };

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_payload_type  req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_payload_type  rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_wdata = '0;

   rsp_payload_type  waypoint_q [$];
   int unsigned      points_per_request = STEP_COUNT_RESET;
   int unsigned      ready_hold = 0;
   int unsigned      mismatch_count = 0;
   int unsigned      points_checked = 0;
   int unsigned      requests_sent = 0;
   int unsigned      settings_used = 0;
   longint           cycle_count = 0;

   quintic_joint_trajectory_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Way-point i of n along the rest-to-rest quintic blend.
   function automatic rsp_payload_type way_point(req_payload_type rq, int unsigned n,
                                                 int unsigned i);
      logic signed [ANGLE_W-1:0] st [JOINT_COUNT];
      logic signed [ANGLE_W-1:0] gl [JOINT_COUNT];
      logic signed [ANGLE_W-1:0] ang [JOINT_COUNT];
      u64_t                      t, t2, t3, p, s;
      longint                    w;
      rsp_payload_type           wp;
      st = '{rq.start_angle_1, rq.start_angle_2, rq.start_angle_3, rq.start_angle_4};
      gl = '{rq.goal_angle_1, rq.goal_angle_2, rq.goal_angle_3, rq.goal_angle_4};
      t  = (u64_t'(i) << Q_FRAC) / u64_t'(n - 1);
      t2 = (t * t + HALF_LSB) >> Q_FRAC;
      t3 = (t2 * t + HALF_LSB) >> Q_FRAC;
      // add before subtract so the tail never wraps
      p  = BLEND_C5 * t2 + BLEND_C3 * u64_t'(Q_ONE) - BLEND_C4 * t;
      s  = (t3 * p + HALF_LSB) >> Q_FRAC;
      for (int j = 0; j < JOINT_COUNT; j++) begin
         w = longint'(st[j]) + (((longint'(gl[j]) - longint'(st[j])) * longint'(s)
                                 + longint'(HALF_LSB)) >>> Q_FRAC);
         if (w < ANGLE_LO) w = ANGLE_LO;
         if (w > ANGLE_HI) w = ANGLE_HI;
         ang[j] = w[ANGLE_W-1:0];
      end
      wp.step_index  = STEP_W'(i);
      wp.way_angle_1 = ang[0];
      wp.way_angle_2 = ang[1];
      wp.way_angle_3 = ang[2];
      wp.way_angle_4 = ang[3];
      wp.last_point  = (i == n - 1);
      return wp;
   endfunction

   function automatic logic [ANGLE_W-1:0] pick_angle();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return ANGLE_W'($urandom_range(0, 15)) - 16'd8;
         default: return ANGLE_W'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 30) $display("MISMATCH @%0t: %s", $time, what);
   endtask

   task automatic send_request(req_payload_type rq, int unsigned typed_points);
      int unsigned     gap;
      int unsigned     n;
      rsp_payload_type wp;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: gap = 0;
         9:             gap = $urandom_range(10, 40);
         default:       gap = $urandom_range(1, 3);
      endcase
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!req_ready);
      n = (typed_points != 0) ? typed_points : points_per_request;
      for (int unsigned i = 0; i < n; i++) begin
         wp = way_point(rq, n, i);
         if (typed_points != 0 && i == 0)
            {wp.way_angle_1, wp.way_angle_2, wp.way_angle_3, wp.way_angle_4} =
               rq[2*JOINT_COUNT*ANGLE_W-1 -: JOINT_COUNT*ANGLE_W];
         if (typed_points != 0 && i == n - 1)
            {wp.way_angle_1, wp.way_angle_2, wp.way_angle_3, wp.way_angle_4} =
               rq[JOINT_COUNT*ANGLE_W-1:0];
         waypoint_q.push_back(wp);
      end
      requests_sent++;
   endtask

   task automatic wait_idle(int unsigned settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (waypoint_q.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_step_count(logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (value < STEP_COUNT_MIN)      points_per_request = STEP_COUNT_MIN;
      else if (value > STEP_COUNT_MAX) points_per_request = STEP_COUNT_MAX;
      else                             points_per_request = value;
      settings_used++;
   endtask

   // result side: mostly short stalls and open stretches, with a few long ones of each
   always @(posedge clock) begin : rsp_backpressure
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_ready) begin
         rsp_ready  <= 1'b0;
         ready_hold <= (pick < 85) ? $urandom_range(0, 2) : $urandom_range(9, 39);
      end else begin
         rsp_ready  <= 1'b1;
         ready_hold <= (pick < 90) ? $urandom_range(0, 11) : $urandom_range(99, 299);
      end
   end

   always @(posedge clock) begin : waypoint_check
      rsp_payload_type           want;
      logic signed [ANGLE_W-1:0] got_a [JOINT_COUNT];
      logic signed [ANGLE_W-1:0] want_a [JOINT_COUNT];
      if (!reset && rsp_valid && rsp_ready) begin
         if (waypoint_q.size() == 0) begin
            report_mismatch($sformatf("way-point %0d arrived with nothing expected",
                                      rsp_data.step_index));
         end else begin
            want = waypoint_q.pop_front();
            points_checked++;
            got_a  = '{rsp_data.way_angle_1, rsp_data.way_angle_2,
                       rsp_data.way_angle_3, rsp_data.way_angle_4};
            want_a = '{want.way_angle_1, want.way_angle_2,
                       want.way_angle_3, want.way_angle_4};
            if (rsp_data.step_index !== want.step_index)
               report_mismatch($sformatf("step_index got %0d, want %0d",
                                         rsp_data.step_index, want.step_index));
            for (int j = 0; j < JOINT_COUNT; j++) begin
               if (got_a[j] !== want_a[j])
                  report_mismatch($sformatf("step %0d joint %0d angle got %0d, want %0d",
                                            want.step_index, j + 1, got_a[j], want_a[j]));
            end
            if (rsp_data.last_point !== want.last_point)
               report_mismatch($sformatf("step %0d last_point got %0b, want %0b",
                                         want.step_index, rsp_data.last_point,
                                         want.last_point));
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout at %0t with %0d way-points outstanding", $time, waypoint_q.size());
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      logic [ANGLE_W-1:0] st_a [JOINT_COUNT];
      logic [ANGLE_W-1:0] gl_a [JOINT_COUNT];
      logic [CFG_W-1:0]   setting;
      req_payload_type    rq;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[k]) begin
         if (directed_plan[k].do_write) begin
            wait_idle(20);
            write_step_count(directed_plan[k].csr_value);
         end
         send_request(directed_plan[k].rq, directed_plan[k].typed_points);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 6)
            0:       setting = CFG_W'($urandom_range(0, 2));
            1:       setting = CFG_W'($urandom_range(3, 6));
            2:       setting = CFG_W'($urandom_range(7, 16));
            3:       setting = CFG_W'($urandom_range(2, 10));
            4:       setting = CFG_W'($urandom_range(0, 127));
            default: setting = CFG_W'($urandom_range(17, 32));
         endcase
         wait_idle(20);
         write_step_count(setting);
         repeat (PHASE_ITEMS) begin
            for (int j = 0; j < JOINT_COUNT; j++) begin
               st_a[j] = pick_angle();
               // occasionally a joint that does not move
               gl_a[j] = ($urandom_range(0, 9) == 0) ? st_a[j] : pick_angle();
            end
            rq = '{st_a[0], st_a[1], st_a[2], st_a[3], gl_a[0], gl_a[1], gl_a[2], gl_a[3]};
            send_request(rq, 0);
         end
      end

      wait_idle(100);
      $display("Ran %0d trajectory requests under %0d step-count writes,", requests_sent,
               settings_used);
      $display("checking %0d way-points; %0d mismatches.", points_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
